// File: sv/sri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_pkg - shared types and constants
// Request/response structs, divider status and sequencer states for the
// strided range intersection unit.
// ----------------------------------------------------------------------------
package sri_pkg;

	localparam int ADDR_W = 32;
	localparam int DW     = 2 * ADDR_W;
	localparam int CNT_W  = $clog2(DW) + 1;

	typedef struct packed {
		logic [31:0] start_a;
		logic [31:0] end_a;
		logic [31:0] step_a;
		logic [31:0] start_b;
		logic [31:0] end_b;
		logic [31:0] step_b;
	} sri_req_t;

	typedef struct packed {
		logic        overlap;
		logic [31:0] first_shared;
		logic [63:0] shared_step;
		logic [32:0] shared_count;
	} sri_rsp_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quo;
		logic [DW-1:0] rem;
	} div_res_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_DWAIT, ST_DELTA, ST_GCD, ST_GSTEP, ST_GCHK,
		ST_MQ, ST_S2G, ST_LCM, ST_DGM, ST_INV0, ST_INVL, ST_INVQ, ST_INVU,
		ST_INVF, ST_KMOD, ST_OFFS, ST_CNT0, ST_FIN, ST_ZERO, ST_OUT
	} sri_state_t;

endpackage
`default_nettype wire

// File: sv/sri_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_div - shared restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module sri_div import sri_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output div_res_t           res
);
	logic [DW-1:0]    rem_q, quo_q, d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			// subtract where the shifted remainder covers the divisor
			rem_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;
endmodule
`default_nettype wire

// File: sv/sri_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_mul - shared registered multiplier
// Unsigned ADDR_W by ADDR_W product, loaded on go and held otherwise.
// ----------------------------------------------------------------------------
module sri_mul import sri_pkg::*; (
	input  wire logic              clk,
	input  wire logic              go,
	input  wire logic [ADDR_W-1:0] a,
	input  wire logic [ADDR_W-1:0] b,
	output logic      [DW-1:0]     p
);
	logic [DW-1:0] p_q;

	always_ff @(posedge clk) begin
		if (go) begin
			p_q <= DW'(a) * DW'(b);
		end
	end

	assign p = p_q;
endmodule
`default_nettype wire

// File: sv/strided_range_intersection_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strided_range_intersection_unit - gcd / extended Euclid range intersection
// Orders two strided ranges by start, then finds first shared address, lcm
// stride and shared count using one shared divider and one multiplier.
//
//   channel | signals                      | direction
//   in      | in_valid, in_ready, in_data  | request in
//   out     | out_valid, out_ready, out_data | response out
//
// Each divide holds the sequencer in ST_DWAIT until the shared divider is done.
// A request rejected on stride or bounds leaves without a divide; a full one needs
// eight divides plus one per Euclid step in each of the gcd and inverse loops.
// One request is in flight at a time; in_ready is high only when idle. A response
// holds in the output register until taken. Reset clears the sequencer; no memory
// needs clearing.
// ----------------------------------------------------------------------------
module strided_range_intersection_unit import sri_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sri_req_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output sri_rsp_t  out_data
);
	localparam int AW = ADDR_W;

	sri_state_t state_q, state_d, ret_q, ret_d;

	logic [AW-1:0] lo1_q, hi1_q, s1_q, lo2_q, hi2_q, s2_q;
	logic [AW-1:0] span_q, delta_q, x_q, y_q, dg_q, m_q, s2g_q, dgm_q;
	logic [AW-1:0] r_q, nr_q;
	logic [DW-1:0] lcm_q, off_q;
	logic [AW+1:0] t_q, nt_q;
	sri_rsp_t      res_q;

	logic          div_start;
	logic [DW-1:0] div_n, div_d;
	div_res_t      div_res;
	logic          mul_go;
	logic [AW-1:0] mul_a, mul_b;
	logic [DW-1:0] mul_p;

	logic [AW-1:0] a_lo, a_hi, a_st, b_lo, b_hi, b_st;
	logic          swap;
	logic [AW-1:0] hi_min;
	logic          early_zero;
	logic [AW+1:0] nt_abs;
	logic [DW+1:0] t_ext, prod_e, tt_w;
	logic [AW+1:0] t_adj, inv_w;
	logic [AW:0]   cnt_w;

	assign a_lo = in_data.start_a[AW-1:0];
	assign a_hi = in_data.end_a[AW-1:0];
	assign a_st = in_data.step_a[AW-1:0];
	assign b_lo = in_data.start_b[AW-1:0];
	assign b_hi = in_data.end_b[AW-1:0];
	assign b_st = in_data.step_b[AW-1:0];
	assign swap = b_lo < a_lo;

	assign hi_min     = (hi1_q < hi2_q) ? hi1_q : hi2_q;
	assign early_zero = (s1_q == '0) || (s2_q == '0) || (hi_min < lo2_q);

	assign nt_abs = nt_q[AW+1] ? (~nt_q + 1'b1) : nt_q;
	assign t_ext  = {{(DW-AW){t_q[AW+1]}}, t_q};
	assign prod_e = {2'b00, mul_p};
	// tt = t - q * nt, with the sign of nt folded back in
	assign tt_w   = nt_q[AW+1] ? (t_ext + prod_e) : (t_ext - prod_e);
	assign t_adj  = t_q[AW+1] ? (t_q + {2'b00, m_q}) : t_q;
	assign inv_w  = (t_adj >= {2'b00, m_q}) ? (t_adj - {2'b00, m_q}) : t_adj;
	assign cnt_w  = {1'b0, div_res.quo[AW-1:0]} + 1'b1;

	sri_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.res      (div_res)
	);

	sri_mul u_mul (
		.clk (clk),
		.go  (mul_go),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CHECK;
			ST_CHECK: state_d = early_zero ? ST_ZERO : ST_DWAIT;
			ST_DWAIT: if (div_res.done) state_d = ret_q;
			ST_DELTA: state_d = ST_GCD;
			ST_GCD:   state_d = ST_DWAIT;
			ST_GSTEP: state_d = ST_GCD;
			ST_GCHK:  state_d = (div_res.rem != '0) ? ST_ZERO : ST_DWAIT;
			ST_MQ:    state_d = ST_DWAIT;
			ST_S2G:   state_d = ST_LCM;
			ST_LCM:   state_d = ST_DWAIT;
			ST_DGM:   state_d = (m_q <= AW'(1)) ? ST_INVF : ST_DWAIT;
			ST_INV0:  state_d = ST_INVL;
			ST_INVL:  state_d = (nr_q == '0) ? ST_INVF : ST_DWAIT;
			ST_INVQ:  state_d = ST_INVU;
			ST_INVU:  state_d = ST_INVL;
			ST_INVF:  state_d = ST_KMOD;
			ST_KMOD:  state_d = ST_DWAIT;
			ST_OFFS:  state_d = ST_CNT0;
			ST_CNT0:  state_d = (mul_p > DW'(span_q)) ? ST_ZERO : ST_DWAIT;
			ST_FIN:   state_d = ST_OUT;
			ST_ZERO:  state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit control
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		ret_d     = ret_q;
		mul_go    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_CHECK: begin
				div_start = !early_zero;
				div_n     = DW'(lo2_q - lo1_q);
				div_d     = DW'(s1_q);
				ret_d     = ST_DELTA;
			end
			ST_GCD: begin
				div_start = 1'b1;
				if (y_q == '0) begin
					div_n = DW'(delta_q);
					div_d = DW'(x_q);
					ret_d = ST_GCHK;
				end else begin
					div_n = DW'(x_q);
					div_d = DW'(y_q);
					ret_d = ST_GSTEP;
				end
			end
			ST_GCHK: begin
				div_start = (div_res.rem == '0);
				div_n     = DW'(s1_q);
				div_d     = DW'(x_q);
				ret_d     = ST_MQ;
			end
			ST_MQ: begin
				div_start = 1'b1;
				div_n     = DW'(s2_q);
				div_d     = DW'(x_q);
				ret_d     = ST_S2G;
			end
			ST_S2G: begin
				mul_go = 1'b1;
				mul_a  = m_q;
				mul_b  = s2_q;
			end
			ST_LCM: begin
				div_start = 1'b1;
				div_n     = DW'(dg_q);
				div_d     = DW'(m_q);
				ret_d     = ST_DGM;
			end
			ST_DGM: begin
				div_start = (m_q > AW'(1));
				div_n     = DW'(s2g_q);
				div_d     = DW'(m_q);
				ret_d     = ST_INV0;
			end
			ST_INVL: begin
				div_start = (nr_q != '0);
				div_n     = DW'(r_q);
				div_d     = DW'(nr_q);
				ret_d     = ST_INVQ;
			end
			ST_INVQ: begin
				mul_go = 1'b1;
				mul_a  = div_res.quo[AW-1:0];
				mul_b  = nt_abs[AW-1:0];
			end
			ST_INVF: begin
				mul_go = 1'b1;
				mul_a  = inv_w[AW-1:0];
				mul_b  = dgm_q;
			end
			ST_KMOD: begin
				div_start = 1'b1;
				div_n     = mul_p;
				div_d     = DW'(m_q);
				ret_d     = ST_OFFS;
			end
			ST_OFFS: begin
				mul_go = 1'b1;
				mul_a  = s2_q;
				mul_b  = div_res.rem[AW-1:0];
			end
			ST_CNT0: begin
				div_start = (mul_p <= DW'(span_q));
				div_n     = DW'(span_q) - mul_p;
				div_d     = lcm_q;
				ret_d     = ST_FIN;
			end
			ST_OUT:   out_valid = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			if (div_start) begin
				ret_q <= ret_d;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lo1_q <= swap ? b_lo : a_lo;
				hi1_q <= swap ? b_hi : a_hi;
				s1_q  <= swap ? b_st : a_st;
				lo2_q <= swap ? a_lo : b_lo;
				hi2_q <= swap ? a_hi : b_hi;
				s2_q  <= swap ? a_st : b_st;
			end
			ST_CHECK: span_q <= hi_min - lo2_q;
			ST_DELTA: begin
				delta_q <= (div_res.rem == '0) ? '0 : s1_q - div_res.rem[AW-1:0];
				x_q     <= s1_q;
				y_q     <= s2_q;
			end
			ST_GSTEP: begin
				x_q <= y_q;
				y_q <= div_res.rem[AW-1:0];
			end
			ST_GCHK:  dg_q  <= div_res.quo[AW-1:0];
			ST_MQ:    m_q   <= div_res.quo[AW-1:0];
			ST_S2G:   s2g_q <= div_res.quo[AW-1:0];
			ST_LCM:   lcm_q <= mul_p;
			ST_DGM: begin
				dgm_q <= div_res.rem[AW-1:0];
				t_q   <= '0;
			end
			ST_INV0: begin
				r_q  <= m_q;
				nr_q <= div_res.rem[AW-1:0];
				t_q  <= '0;
				nt_q <= {{(AW+1){1'b0}}, 1'b1};
			end
			ST_INVU: begin
				t_q  <= nt_q;
				nt_q <= tt_w[AW+1:0];
				r_q  <= nr_q;
				nr_q <= div_res.rem[AW-1:0];
			end
			ST_CNT0:  off_q <= mul_p;
			ST_FIN: begin
				res_q.overlap      <= 1'b1;
				res_q.first_shared <= {{(32-AW){1'b0}}, lo2_q + off_q[AW-1:0]};
				res_q.shared_step  <= {{(64-DW){1'b0}}, lcm_q};
				res_q.shared_count <= {{(33-(AW+1)){1'b0}}, cnt_w};
			end
			ST_ZERO:  res_q <= '0;
			default:  ;
		endcase
	end

	assign out_data = res_q;
endmodule
`default_nettype wire

// File: sv/sri_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_chk - port checker
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module sri_chk import sri_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input sri_req_t  in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input sri_rsp_t  out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response dropped or changed while stalled");

	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken while a response is pending");

	a_zero_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.overlap |-> out_data.first_shared == '0 &&
			out_data.shared_step == '0 && out_data.shared_count == '0)
		else $error("non-overlap response carries data");

	a_hit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overlap |-> out_data.shared_step != '0 &&
			out_data.shared_count != '0)
		else $error("overlap response with zero stride or count");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("response in the cycle after a request");
endmodule

bind strided_range_intersection_unit sri_chk u_sri_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench - strided range intersection unit
// Drives request pairs of strided ranges through the valid/ready handshake,
// predicts first shared address, lcm stride and shared count, and checks
// each response field by field under several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	import sri_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sri_req_t in_data;
	logic     out_valid;
	logic     out_ready;
	sri_rsp_t out_data;

	sri_rsp_t expected_q[$];
	int       n_errors;
	int       n_checked;
	int       n_overlaps;
	int       send_idle_pct;
	int       recv_stall_pct;
	longint   cycle_count;

	localparam longint CYCLE_LIMIT = 64'd20_000_000;

	strided_range_intersection_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		return x;
	endfunction

	function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] m);
		longint      t;
		longint      nt;
		longint      tt;
		logic [63:0] r;
		logic [63:0] nr;
		logic [63:0] q;
		logic [63:0] rr;
		t  = 0;
		nt = 1;
		if (m <= 1)
			return 0;
		r  = m;
		nr = a % m;
		while (nr != 0) begin
			q  = r / nr;
			tt = t - longint'(q) * nt;
			rr = r - q * nr;
			t  = nt;
			nt = tt;
			r  = nr;
			nr = rr;
		end
		if (t < 0)
			t += longint'(m);
		return 64'(t) % m;
	endfunction

	function automatic sri_rsp_t intersect_ranges(sri_req_t rq);
		sri_rsp_t    rs;
		logic [63:0] lo1, hi1, s1, lo2, hi2, s2, t;
		logic [63:0] hi, span, delta, g, m, lcm, k, offset, count;
		rs  = '0;
		lo1 = 64'(rq.start_a);
		hi1 = 64'(rq.end_a);
		s1  = 64'(rq.step_a);
		lo2 = 64'(rq.start_b);
		hi2 = 64'(rq.end_b);
		s2  = 64'(rq.step_b);
		if (lo2 < lo1) begin
			t = lo1; lo1 = lo2; lo2 = t;
			t = hi1; hi1 = hi2; hi2 = t;
			t = s1;  s1 = s2;   s2 = t;
		end
		if (s1 == 0 || s2 == 0)
			return rs;
		hi = (hi1 < hi2) ? hi1 : hi2;
		if (hi < lo2)
			return rs;
		span  = hi - lo2;
		delta = (s1 - ((lo2 - lo1) % s1)) % s1;
		g     = gcd64(s1, s2);
		if (delta % g != 0)
			return rs;
		m      = s1 / g;
		lcm    = m * s2;
		k      = (mod_inverse(s2 / g, m) * ((delta / g) % m)) % m;
		offset = s2 * k;
		if (offset > span)
			return rs;
		count = (span - offset) / lcm + 1;
		rs.overlap      = 1'b1;
		rs.first_shared = 32'(lo2 + offset);
		rs.shared_step  = lcm;
		rs.shared_count = 33'(count);
		return rs;
	endfunction

	task automatic send_request(sri_req_t rq);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= rq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_q.push_back(intersect_ranges(rq));
		@(negedge clk);
		in_valid <= 1'b0;
		// drop valid for one cycle before the next request
		@(negedge clk);
	endtask

	task automatic send_ranges(logic [31:0] sa, logic [31:0] ea, logic [31:0] pa,
			logic [31:0] sb, logic [31:0] eb, logic [31:0] pb);
		sri_req_t rq;
		rq = '{start_a: sa, end_a: ea, step_a: pa, start_b: sb, end_b: eb, step_b: pb};
		send_request(rq);
	endtask

	task automatic drain_responses();
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// receiver stall and response compare
	always @(negedge clk) begin
		out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		sri_rsp_t exp_rsp;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL strided_range_intersection_unit");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("response with no request outstanding");
				n_errors++;
			end else begin
				exp_rsp = expected_q.pop_front();
				n_checked++;
				if (exp_rsp.overlap)
					n_overlaps++;
				if (out_data.overlap !== exp_rsp.overlap) begin
					$error("overlap exp %0d got %0d", exp_rsp.overlap, out_data.overlap);
					n_errors++;
				end
				if (out_data.first_shared !== exp_rsp.first_shared) begin
					$error("first_shared exp %0h got %0h", exp_rsp.first_shared,
						out_data.first_shared);
					n_errors++;
				end
				if (out_data.shared_step !== exp_rsp.shared_step) begin
					$error("shared_step exp %0h got %0h", exp_rsp.shared_step,
						out_data.shared_step);
					n_errors++;
				end
				if (out_data.shared_count !== exp_rsp.shared_count) begin
					$error("shared_count exp %0h got %0h", exp_rsp.shared_count,
						out_data.shared_count);
					n_errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_ranges(0, 100, 4, 2, 100, 6);               // plain overlap
		send_ranges(2, 100, 6, 0, 100, 4);               // B earlier: swap
		send_ranges(10, 20, 3, 10, 50, 5);               // tie on start
		send_ranges(0, 10, 2, 50, 90, 2);                // bound below later start
		send_ranges(0, 100, 4, 1, 100, 4);               // no congruence solution
		send_ranges(0, 30, 7, 5, 30, 11);                // offset beyond overlap
		send_ranges(3, 1000, 5, 100, 1000, 7);           // negative residue path
		send_ranges(0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 1); // full count
		send_ranges(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_ranges(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_ranges(0, 0, 1, 0, 0, 1);
		send_ranges(1, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
		send_ranges(0, 100, 0, 0, 100, 3);               // zero stride
		send_ranges(5, 100, 3, 5, 100, 0);
		send_ranges(32'h8000_0000, 32'hFFFF_FFF0, 12, 32'h8000_0004, 32'hFFFF_FFFF, 18);
		send_ranges(100, 50, 2, 100, 200, 2);            // end below own start
	endtask

	task automatic random_ranges(int n);
		sri_req_t rq;
		logic [31:0] base;
		repeat (n) begin
			if ($urandom_range(3) == 0) begin
				rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				if ($urandom_range(7) != 0) begin
					if (rq.step_a == 0) rq.step_a = 1;
					if (rq.step_b == 0) rq.step_b = 1;
				end
			end else begin
				// overlapping windows with small, common-factor strides
				base       = $urandom;
				rq.start_a = base + $urandom_range(255);
				rq.start_b = base + $urandom_range(255);
				rq.end_a   = base + $urandom_range(65535);
				rq.end_b   = base + $urandom_range(65535);
				rq.step_a  = $urandom_range(1, 24) * ($urandom_range(1) ? 1 : 6);
				rq.step_b  = $urandom_range(1, 24) * ($urandom_range(1) ? 1 : 6);
				if ($urandom_range(9) == 0) begin
					rq.step_a = $urandom | 32'h1;
					rq.end_a  = 32'hFFFF_FFFF;
					rq.end_b  = 32'hFFFF_FFFF;
				end
			end
			send_request(rq);
		end
	endtask

	task automatic test_no_idling();
		send_idle_pct = 0; recv_stall_pct = 0;
		random_ranges(75);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 56; recv_stall_pct = 0;
		random_ranges(75);
		// hold until every response is back, then resume
		drain_responses();
		random_ranges(5);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0; recv_stall_pct = 56;
		random_ranges(70);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 17; recv_stall_pct = 17;
		random_ranges(75);
	endtask

	initial begin
		n_errors       = 0;
		n_checked      = 0;
		n_overlaps     = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		drain_responses();
		$display("Checked %0d responses, %0d with shared addresses, across four idling mixes.",
			n_checked, n_overlaps);
		if (n_errors == 0)
			$display("PASS strided_range_intersection_unit");
		else
			$display("FAIL strided_range_intersection_unit");
		$finish;
	end

endmodule
`default_nettype wire

// File: strided_range_intersection_unit.f
sv/sri_pkg.sv
sv/sri_div.sv
sv/sri_mul.sv
sv/strided_range_intersection_unit.sv
sv/sri_chk.sv
tb/sv/testbench.sv
